[design/adp_pkg.sv]
`timescale 1ns / 1ps
package adp_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int KAPPA_BITS  = 24;
	localparam int GAIN_BITS   = 15;
	localparam int K2_BITS     = 2 * KAPPA_BITS;
	localparam int G_BITS      = SAMPLE_BITS + 1;
	localparam int G2_BITS     = 2 * SAMPLE_BITS;
	localparam int W_BITS      = 17;
	localparam int DIV_Q_BITS  = W_BITS;
	localparam int DIV_R_BITS  = 64;
	localparam int PROD_BITS   = W_BITS + 1 + G_BITS;
	localparam int SUM_BITS    = PROD_BITS + 2;
	localparam int ACC_BITS    = SUM_BITS + GAIN_BITS + 1;
	localparam int LANES       = 4;
	localparam int ROM_DEPTH   = 256;
	localparam int IDX_BITS    = 8;
	localparam int EXP_SHIFT   = 5;
	localparam int RANGE_SHIFT = 3;

	localparam logic MODE_EXP      = 1'b0;
	localparam logic MODE_RATIONAL = 1'b1;

	typedef enum logic [1:0] {
		REG_MODE      = 2'd0,
		REG_THRESHOLD = 2'd1,
		REG_GAIN      = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic                     mode;
		logic                     zero;
		logic signed [G_BITS-1:0] g;
	} div_tag_t;

	typedef logic [ROM_DEPTH-1:0][W_BITS-1:0] exp_rom_t;

	// Entry i is exp(-i/32) in Q1.16, built by repeated Q0.32 multiplication.
	function automatic exp_rom_t build_exp_rom();
		logic [63:0] t;
		exp_rom_t    r;
		t = 64'h1_0000_0000;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			r[i] = W_BITS'((t + 64'd32768) >> 16);
			t = (t * 64'd4162825044 + 64'h8000_0000) >> 32;
		end
		return r;
	endfunction

	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

[design/adp_div.sv]
`timescale 1ns / 1ps
module adp_div import adp_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DIV_R_BITS-1:0] a,
	input  logic [K2_BITS-1:0]    b,
	input  div_tag_t              tag_in,
	output logic [DIV_Q_BITS-1:0] quo,
	output div_tag_t              tag_out
);

	// One restoring step per stage, most significant quotient bit first.
	logic [DIV_R_BITS-1:0] rem_s [DIV_Q_BITS];
	logic [K2_BITS-1:0]    b_s   [DIV_Q_BITS];
	logic [DIV_Q_BITS-1:0] q_s   [DIV_Q_BITS];
	div_tag_t              tag_s [DIV_Q_BITS];

	for (genvar k = 0; k < DIV_Q_BITS; k++) begin : g_step
		logic [DIV_R_BITS-1:0] rem_in;
		logic [K2_BITS-1:0]    b_in;
		logic [DIV_Q_BITS-1:0] q_in;
		div_tag_t              tag_k;
		logic [DIV_R_BITS-1:0] shifted;
		logic [DIV_R_BITS:0]   diff;

		if (k == 0) begin : g_first
			assign rem_in = a;
			assign b_in   = b;
			assign q_in   = '0;
			assign tag_k  = tag_in;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign b_in   = b_s[k-1];
			assign q_in   = q_s[k-1];
			assign tag_k  = tag_s[k-1];
		end

		assign shifted = DIV_R_BITS'(b_in) << (DIV_Q_BITS - 1 - k);
		assign diff    = {1'b0, rem_in} - {1'b0, shifted};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= diff[DIV_R_BITS] ? rem_in : diff[DIV_R_BITS-1:0];
				q_s[k]   <= {q_in[DIV_Q_BITS-2:0], ~diff[DIV_R_BITS]};
				b_s[k]   <= b_in;
				tag_s[k] <= tag_k;
			end
		end
	end

	assign quo     = q_s[DIV_Q_BITS-1];
	assign tag_out = tag_s[DIV_Q_BITS-1];

endmodule

[design/adp_lane.sv]
`timescale 1ns / 1ps
module adp_lane import adp_pkg::*; (
	input  logic                        clk,
	input  logic                        en,
	input  logic                        mode,
	input  logic [K2_BITS-1:0]          k2,
	input  logic [SAMPLE_BITS-1:0]      nbr_s1,
	input  logic [SAMPLE_BITS-1:0]      centre_s1,
	output logic signed [PROD_BITS-1:0] prod_s23
);

	logic signed [G_BITS-1:0]      g_d, g_neg;
	logic [SAMPLE_BITS-1:0]        mag_d;
	logic signed [G_BITS-1:0]      g_s2, g_s3;
	logic [SAMPLE_BITS-1:0]        mag_s2;
	logic [G2_BITS-1:0]            g2_s3;

	assign g_d   = $signed({1'b0, nbr_s1}) - $signed({1'b0, centre_s1});
	assign g_neg = -g_d;
	assign mag_d = g_d[G_BITS-1] ? g_neg[SAMPLE_BITS-1:0] : g_d[SAMPLE_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			g_s2   <= g_d;
			mag_s2 <= mag_d;
			g_s3   <= g_s2;
			g2_s3  <= mag_s2 * mag_s2;
		end
	end

	// Divider operands: 32*g^2 / kappa^2 for the table index, or the rounded
	// quotient kappa^2 / (kappa^2 + g^2) in Q1.16 after bringing d below 2^47.
	logic [K2_BITS+RANGE_SHIFT-1:0] k2_x8;
	logic                           zero_d;
	logic [K2_BITS:0]               dsum, dnorm;
	logic [K2_BITS-1:0]             nnorm;
	logic [DIV_R_BITS-1:0]          a_d;
	logic [K2_BITS-1:0]             b_d;

	assign k2_x8  = {k2, {RANGE_SHIFT{1'b0}}};
	assign zero_d = (K2_BITS+RANGE_SHIFT)'(g2_s3) >= k2_x8;
	assign dsum   = {1'b0, k2} + (K2_BITS+1)'(g2_s3);

	always_comb begin
		if (dsum[K2_BITS]) begin
			dnorm = dsum >> 2;
			nnorm = k2 >> 2;
		end else if (dsum[K2_BITS-1]) begin
			dnorm = dsum >> 1;
			nnorm = k2 >> 1;
		end else begin
			dnorm = dsum;
			nnorm = k2;
		end
		if (mode == MODE_RATIONAL) begin
			a_d = {nnorm, 16'b0} + DIV_R_BITS'(dnorm[K2_BITS:1]);
			b_d = dnorm[K2_BITS-1:0];
		end else begin
			a_d = DIV_R_BITS'({g2_s3, {EXP_SHIFT{1'b0}}});
			b_d = k2;
		end
	end

	logic [DIV_R_BITS-1:0] a_s4;
	logic [K2_BITS-1:0]    b_s4;
	div_tag_t              tag_s4, tag_s21;
	logic [DIV_Q_BITS-1:0] q_s21;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4        <= a_d;
			b_s4        <= b_d;
			tag_s4.mode <= mode;
			tag_s4.zero <= zero_d;
			tag_s4.g    <= g_s3;
		end
	end

	adp_div u_div (
		.clk     (clk),
		.en      (en),
		.a       (a_s4),
		.b       (b_s4),
		.tag_in  (tag_s4),
		.quo     (q_s21),
		.tag_out (tag_s21)
	);

	logic [W_BITS-1:0]        w_d, w_s22;
	logic signed [G_BITS-1:0] g_s22;

	always_comb begin
		if (tag_s21.mode == MODE_RATIONAL)
			w_d = q_s21;
		else if (tag_s21.zero)
			w_d = '0;
		else
			w_d = EXP_ROM[q_s21[IDX_BITS-1:0]];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s22    <= w_d;
			g_s22    <= tag_s21.g;
			prod_s23 <= $signed({1'b0, w_s22}) * g_s22;
		end
	end

endmodule

[design/anisotropic_diffusion_pixel_top.sv]
`timescale 1ns / 1ps
// Channel | Signals                                               | Transfer
// --------+-------------------------------------------------------+---------------------
// in      | in_valid/in_ready, centre/north/south/east/west_value, | valid & ready at clk
//         | in_mask                                               |
// out     | out_valid/out_ready, new_value                        | valid & ready at clk
// cfg     | psel/penable/pwrite/paddr/pwdata/prdata/pready        | psel & penable & pwrite
//
// One transfer per cycle is sustained while out_ready stays high; the pipeline depth is set
// mostly by the 17-step restoring divider that each of the four neighbor lanes carries.
// arst_n clears the valid bits and loads the register reset values.
// A stall at the output freezes the whole pipeline in place; in_ready drops only
// while a finished result waits.
module anisotropic_diffusion_pixel_top import adp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] centre_value,
	input  logic [SAMPLE_BITS-1:0] north_value,
	input  logic [SAMPLE_BITS-1:0] south_value,
	input  logic [SAMPLE_BITS-1:0] east_value,
	input  logic [SAMPLE_BITS-1:0] west_value,
	input  logic                   in_mask,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] new_value,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int NUM_STAGES = 26;
	localparam int ACC_STAGE  = NUM_STAGES - 1;
	localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(64'h8000_0000);

	// Configuration registers.
	logic                  mode_q;
	logic [KAPPA_BITS-1:0] thr_q;
	logic [GAIN_BITS-1:0]  gain_q;
	logic [K2_BITS-1:0]    k2_q;
	logic [KAPPA_BITS-1:0] kappa;
	reg_idx_t              reg_idx;

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EXP;
			thr_q  <= KAPPA_BITS'(1310720);
			gain_q <= GAIN_BITS'(16384);
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_MODE:      mode_q <= pwdata[0];
				REG_THRESHOLD: thr_q  <= pwdata[KAPPA_BITS-1:0];
				REG_GAIN:      gain_q <= pwdata[GAIN_BITS-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:      prdata = 32'(mode_q);
			REG_THRESHOLD: prdata = 32'(thr_q);
			REG_GAIN:      prdata = 32'(gain_q);
			default:       prdata = '0;
		endcase
	end

	// A zero threshold acts as one.
	assign kappa = (thr_q == '0) ? KAPPA_BITS'(1) : thr_q;

	always_ff @(posedge clk) begin
		k2_q <= kappa * kappa;
	end

	// Pipeline control.
	logic [NUM_STAGES:1] stage_vld_q;
	logic                en;

	assign en        = !stage_vld_q[NUM_STAGES] || out_ready;
	assign in_ready  = en;
	assign out_valid = stage_vld_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stage_vld_q <= '0;
		else if (en)
			stage_vld_q <= {stage_vld_q[NUM_STAGES-1:1], in_valid};
	end

	// Input stage and side data.
	logic [SAMPLE_BITS-1:0] nbr_s1 [LANES];
	logic [SAMPLE_BITS-1:0] ctr_s  [1:ACC_STAGE];
	logic                   mask_s [1:ACC_STAGE];

	always_ff @(posedge clk) begin
		if (en) begin
			nbr_s1[0] <= north_value;
			nbr_s1[1] <= south_value;
			nbr_s1[2] <= east_value;
			nbr_s1[3] <= west_value;
			ctr_s[1]  <= centre_value;
			mask_s[1] <= in_mask;
			for (int i = 2; i <= ACC_STAGE; i++) begin
				ctr_s[i]  <= ctr_s[i-1];
				mask_s[i] <= mask_s[i-1];
			end
		end
	end

	logic signed [PROD_BITS-1:0] prod_s23 [LANES];

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		adp_lane u_lane (
			.clk       (clk),
			.en        (en),
			.mode      (mode_q),
			.k2        (k2_q),
			.nbr_s1    (nbr_s1[l]),
			.centre_s1 (ctr_s[1]),
			.prod_s23  (prod_s23[l])
		);
	end

	// Sum, gain, rounding and saturation.
	logic signed [SUM_BITS-1:0] sum_s24;
	logic signed [ACC_BITS-1:0] acc_s25;
	logic [ACC_BITS-1:0]        rnd;
	logic signed [ACC_BITS-33:0] delta;
	logic signed [ACC_BITS-31:0] res;
	logic [SAMPLE_BITS-1:0]     sat;
	logic [SAMPLE_BITS-1:0]     newval_s26;

	assign rnd   = acc_s25 + ROUND_HALF;
	assign delta = $signed(rnd[ACC_BITS-1:32]);
	assign res   = $signed((ACC_BITS-30)'({1'b0, ctr_s[ACC_STAGE]})) + (ACC_BITS-30)'(delta);

	always_comb begin
		if (res[ACC_BITS-31])
			sat = '0;
		else if (|res[ACC_BITS-32:SAMPLE_BITS])
			sat = '1;
		else
			sat = res[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s24    <= SUM_BITS'(prod_s23[0]) + SUM_BITS'(prod_s23[1])
			            + SUM_BITS'(prod_s23[2]) + SUM_BITS'(prod_s23[3]);
			acc_s25    <= sum_s24 * $signed({1'b0, gain_q});
			newval_s26 <= mask_s[ACC_STAGE] ? sat : ctr_s[ACC_STAGE];
		end
	end

	assign new_value = newval_s26;

	// A stall must freeze every valid bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(stage_vld_q))
		else $error("pipeline valid bits moved during a stall");

	// An advancing pipeline takes the input valid into its first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		en |=> stage_vld_q[1] == $past(in_valid))
		else $error("first stage valid does not follow the input");

	// Unmasked pixels leave with their centre sample untouched.
	assert property (@(posedge clk) disable iff (!arst_n)
		en && stage_vld_q[ACC_STAGE] && !mask_s[ACC_STAGE]
		|=> new_value == $past(ctr_s[ACC_STAGE]))
		else $error("unmasked pixel was modified");

endmodule

[tb/anisotropic_diffusion_pixel_checker.sv]
`timescale 1ns / 1ps
module anisotropic_diffusion_pixel_checker import adp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] centre_value,
	input  logic [SAMPLE_BITS-1:0] north_value,
	input  logic [SAMPLE_BITS-1:0] south_value,
	input  logic [SAMPLE_BITS-1:0] east_value,
	input  logic [SAMPLE_BITS-1:0] west_value,
	input  logic                   in_mask,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [SAMPLE_BITS-1:0] new_value,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output int                     fail_count,
	output int                     pending_count,
	output int                     result_count
);

	logic [63:0] exp_weight [ROM_DEPTH];
	logic        mode_q;
	logic [23:0] kappa_q;
	logic [14:0] gain_q;
	logic [SAMPLE_BITS-1:0] expected_values [$];

	initial begin
		logic [63:0] t;
		t = 64'h1_0000_0000;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			exp_weight[i] = (t + 64'd32768) >> 16;
			t = (t * 64'd4162825044 + 64'h8000_0000) >> 32;
		end
	end

	function automatic longint lane_flux(longint g, logic [63:0] k2, logic mode);
		logic [63:0] mag, g2, w, d, n;
		mag = (g < 0) ? -g : g;
		g2 = mag * mag;
		if (mode == MODE_EXP) begin
			if (g2 >= 8 * k2)
				w = 0;
			else
				w = exp_weight[IDX_BITS'((g2 << 5) / k2)];
		end else begin
			d = k2 + g2;
			n = k2;
			while (d >= 64'h8000_0000_0000) begin
				d = d >> 1;
				n = n >> 1;
			end
			w = ((n << 16) + (d >> 1)) / d;
		end
		return longint'(w) * g;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] diffused_value(
		logic [15:0] c, logic [15:0] n, logic [15:0] s, logic [15:0] e,
		logic [15:0] w, logic m);
		longint sum, acc, r;
		logic [63:0] kappa, k2;
		if (!m)
			return c;
		kappa = (kappa_q == 0) ? 64'd1 : 64'(kappa_q);
		k2 = kappa * kappa;
		sum = lane_flux(longint'(n) - longint'(c), k2, mode_q)
			+ lane_flux(longint'(s) - longint'(c), k2, mode_q)
			+ lane_flux(longint'(e) - longint'(c), k2, mode_q)
			+ lane_flux(longint'(w) - longint'(c), k2, mode_q);
		acc = sum * longint'(gain_q) + (longint'(1) << 31);
		// Arithmetic shift floors, which gives round half up.
		r = longint'(c) + (acc >>> 32);
		if (r < 0)
			r = 0;
		if (r > 65535)
			r = 65535;
		return r[15:0];
	endfunction

	assign pending_count = expected_values.size();

	always @(posedge clk or negedge arst_n) begin
		logic [SAMPLE_BITS-1:0] want;
		if (!arst_n) begin
			mode_q <= 1'b0;
			kappa_q <= 24'd1310720;
			gain_q <= 15'd16384;
			expected_values.delete();
			fail_count <= 0;
			result_count <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_values.push_back(diffused_value(centre_value, north_value,
					south_value, east_value, west_value, in_mask));
			if (out_valid && out_ready) begin
				result_count <= result_count + 1;
				if (expected_values.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result transfer new_value=%0d", new_value);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_values.pop_front();
					if (want !== new_value) begin
						if (fail_count < 10)
							$display("new_value mismatch: expected %0d actual %0d",
								want, new_value);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (psel && penable && pwrite) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_MODE:      mode_q <= pwdata[0];
					REG_THRESHOLD: kappa_q <= pwdata[23:0];
					REG_GAIN:      gain_q <= pwdata[14:0];
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/anisotropic_diffusion_pixel_top_test.sv]
`timescale 1ns / 1ps
module anisotropic_diffusion_pixel_top_test import adp_pkg::*; ();

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [SAMPLE_BITS-1:0] centre_value = '0, north_value = '0, south_value = '0;
	logic [SAMPLE_BITS-1:0] east_value = '0, west_value = '0;
	logic in_mask = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SAMPLE_BITS-1:0] new_value;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int fail_count, pending_count, result_count;
	bit calm_sink = 1'b0;
	int pixel_count = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	anisotropic_diffusion_pixel_top dut (.*);

	anisotropic_diffusion_pixel_checker checker_i (.*);

	always @(negedge clk)
		out_ready <= calm_sink ? 1'b1 : ($urandom_range(99) >= 9);

	task automatic write_register(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain_pipeline();
		while (pending_count != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// Drives one pixel and holds it until the transfer happens.
	task automatic send_pixel(logic [15:0] c, logic [15:0] n, logic [15:0] s,
		logic [15:0] e, logic [15:0] w, logic m, bit may_idle);
		while (may_idle && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		centre_value <= c;
		north_value <= n;
		south_value <= s;
		east_value <= e;
		west_value <= w;
		in_mask <= m;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		pixel_count++;
	endtask

	task automatic random_pixels(int count, bit may_idle);
		logic [15:0] c, v [4];
		int spread;
		for (int i = 0; i < count; i++) begin
			c = 16'($urandom);
			spread = $urandom_range(3);
			for (int k = 0; k < 4; k++) begin
				case (spread)
					0: v[k] = 16'($urandom);
					1: v[k] = c + 16'($urandom_range(400)) - 16'd200;
					2: v[k] = c + 16'($urandom_range(8000)) - 16'd4000;
					default: v[k] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				endcase
			end
			send_pixel(c, v[0], v[1], v[2], v[3], $urandom_range(99) < 85, may_idle);
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pixels at the reset register values.
		send_pixel(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		send_pixel(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		send_pixel(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
		send_pixel(16'h1234, 16'hFFFF, 16'd0, 16'h5555, 16'hAAAA, 1'b0, 1'b0);
		send_pixel(16'h8000, 16'h8010, 16'h7FF0, 16'h8100, 16'h7000, 1'b1, 1'b0);
		in_valid <= 1'b0;
		drain_pipeline();

		write_register(REG_MODE, 32'd1);
		send_pixel(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		send_pixel(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
		send_pixel(16'h8000, 16'h9000, 16'h7000, 16'h8001, 16'h7FFF, 1'b1, 1'b0);
		in_valid <= 1'b0;
		drain_pipeline();

		// A zero threshold behaves as one; gain above range is used as given.
		write_register(REG_THRESHOLD, 32'd0);
		write_register(REG_GAIN, 32'h7FFF);
		send_pixel(16'h8000, 16'h8001, 16'h7FFF, 16'h8002, 16'h8000, 1'b1, 1'b0);
		send_pixel(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		in_valid <= 1'b0;
		drain_pipeline();
		write_register(REG_MODE, 32'd0);
		write_register(REG_THRESHOLD, 32'hFFFFFF);
		send_pixel(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		send_pixel(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
		in_valid <= 1'b0;
		drain_pipeline();

		// Random phases across several register settings.
		for (int phase = 0; phase < 8; phase++) begin
			write_register(REG_MODE, phase % 2);
			case (phase)
				0: write_register(REG_THRESHOLD, 32'd1);
				1: write_register(REG_THRESHOLD, 32'hFFFFFF);
				default: write_register(REG_THRESHOLD, $urandom_range(20000, 100));
			endcase
			case (phase)
				2: write_register(REG_GAIN, 32'd0);
				3: write_register(REG_GAIN, 32'd16384);
				default: write_register(REG_GAIN, $urandom_range(16384));
			endcase
			calm_sink = (phase == 4);
			random_pixels(65, phase != 4);
			drain_pipeline();
		end
		calm_sink = 1'b0;

		$display("covered %0d pixels and %0d results over both conduction modes,",
			pixel_count, result_count);
		$display("threshold and gain extremes, masked and unmasked pixels");
		if (fail_count == 0)
			$display("anisotropic_diffusion_pixel_top regression: pass");
		else
			$display("anisotropic_diffusion_pixel_top regression: fail");
		$finish;
	end

	initial begin
		#2ms;
		$display("anisotropic_diffusion_pixel_top regression: fail");
		$finish;
	end

endmodule

[anisotropic_diffusion_pixel_top.f]
design/adp_pkg.sv
design/adp_div.sv
design/adp_lane.sv
design/anisotropic_diffusion_pixel_top.sv
tb/anisotropic_diffusion_pixel_checker.sv
tb/anisotropic_diffusion_pixel_top_test.sv
